### rtl/sms_pkg.sv
package sms_pkg;

    localparam int MAX_SAMPLES = 1024;
    localparam int SMS_AW  = $clog2(MAX_SAMPLES);
    localparam int SMS_CW  = $clog2(MAX_SAMPLES + 1);
    localparam int SMS_SW  = 32 + SMS_AW;
    localparam int SMS_DW  = 128;
    localparam int SMS_DCW = $clog2(SMS_DW);

    typedef struct packed {
        logic signed [31:0] sample;
        logic               last;
    } t_in;

    typedef struct packed {
        logic        [10:0] count;
        logic signed [31:0] mean;
        logic        [30:0] stdev;
        logic signed [31:0] skew;
        logic        [31:0] kurtosis;
        logic signed [31:0] sharpe;
        logic               sharpe_saturated;
        logic               dropped;
    } t_out;

    typedef enum logic [4:0] {
        S_LOAD, S_CHK, S_DIV_GO, S_DIV_WAIT,
        S_P_RD, S_P_DIFF, S_P_SQ, S_P_SQW,
        S_K0, S_K1, S_K2, S_K3, S_K4, S_K5, S_K6, S_K7,
        S_SQ_GO, S_SQ_WAIT,
        S_DS0, S_DS1, S_DS2,
        S_DK0, S_DK1, S_DK2, S_DK3, S_DK4,
        S_FIN
    } t_state;

    typedef enum logic [2:0] {
        J_MEAN, J_M2, J_M3, J_M4, J_SKEW, J_KURT, J_SHARPE
    } t_job;

    typedef enum logic [2:0] {
        OP_AD, OP_P2LO, OP_P2HI, OP_M2LO, OP_M2HI, OP_ROOT
    } t_opnd;

    typedef enum logic [1:0] {
        W_HOLD, W_LOAD, W_ADD32, W_ADD64
    } t_wop;

    typedef enum logic [2:0] {
        A_NONE, A_CLR, A_T2, A_T3, A_T4
    } t_aop;

    typedef struct packed {
        logic  take;
        logic  clr_series;
        logic  idx_clr;
        logic  idx_inc;
        logic  rd;
        logic  diff;
        logic  p2_wr;
        t_aop  aop;
        logic  mul_en;
        t_opnd ma;
        t_opnd mb;
        t_wop  wop;
        logic  div_start;
        logic  div_wr;
        t_job  job;
        logic  sqrt_start;
        logic  root_wr;
        logic  out_load;
    } t_cmd;

    typedef struct packed {
        logic n_ge2;
        logic idx_last;
        logic div_done;
        logic sqrt_done;
        logic out_free;
    } t_sts;

endpackage

### rtl/sms_div.sv
module sms_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [sms_pkg::SMS_DW-1:0] i_num,
    input  logic [sms_pkg::SMS_DW-1:0] i_den,
    output logic                       o_busy,
    output logic                       o_done,
    output logic [sms_pkg::SMS_DW-1:0] o_quot
);

    logic                        r_busy;
    logic                        r_rnd;
    logic                        r_done;
    logic [sms_pkg::SMS_DCW-1:0] r_cnt;
    logic [sms_pkg::SMS_DW-1:0]  r_num;
    logic [sms_pkg::SMS_DW-1:0]  r_den;
    logic [sms_pkg::SMS_DW-1:0]  r_rem;
    logic [sms_pkg::SMS_DW-1:0]  r_quot;
    logic [sms_pkg::SMS_DW-1:0]  trial;
    logic [sms_pkg::SMS_DW-1:0]  twice;
    logic                        ge;

    assign trial = {r_rem[sms_pkg::SMS_DW-2:0], r_num[sms_pkg::SMS_DW-1]};
    assign ge    = (trial >= r_den);
    assign twice = {r_rem[sms_pkg::SMS_DW-2:0], 1'b0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_rnd  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_rnd  <= 1'b0;
                r_cnt  <= '0;
                r_num  <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
                r_quot <= '0;
            end else if (r_busy && !r_rnd) begin
                r_rem  <= ge ? trial - r_den : trial;
                r_quot <= {r_quot[sms_pkg::SMS_DW-2:0], ge};
                r_num  <= {r_num[sms_pkg::SMS_DW-2:0], 1'b0};
                r_cnt  <= r_cnt + 1'b1;
                if (r_cnt == sms_pkg::SMS_DCW'(sms_pkg::SMS_DW - 1)) begin
                    r_rnd <= 1'b1;
                end
            end else if (r_busy) begin
                if (twice >= r_den) begin
                    r_quot <= r_quot + 1'b1;
                end
                r_busy <= 1'b0;
                r_rnd  <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

### rtl/sms_sqrt.sv
module sms_sqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_val,
    output logic        o_done,
    output logic [32:0] o_root
);

    logic        r_busy;
    logic        r_fin;
    logic        r_done;
    logic [63:0] r_v;
    logic [63:0] r_r;
    logic [63:0] r_bit;
    logic [63:0] cand;

    assign cand = r_r + r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_fin  <= 1'b0;
                r_v    <= i_val;
                r_r    <= '0;
                r_bit  <= 64'h4000_0000_0000_0000;
            end else if (r_busy && !r_fin) begin
                if (r_v >= cand) begin
                    r_v <= r_v - cand;
                    r_r <= (r_r >> 1) + r_bit;
                end else begin
                    r_r <= r_r >> 1;
                end
                r_bit <= r_bit >> 2;
                if (r_bit[0]) begin
                    r_fin <= 1'b1;
                end
            end else if (r_busy) begin
                if (r_v > r_r) begin
                    r_r <= r_r + 1'b1;
                end
                r_busy <= 1'b0;
                r_fin  <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_r[32:0];

endmodule

### rtl/sms_ctrl.sv
module sms_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_last,
    input  sms_pkg::t_sts i_sts,
    output logic          o_in_stall,
    output sms_pkg::t_cmd o_cmd
);

    sms_pkg::t_state r_state, n_state;
    sms_pkg::t_job   r_job, n_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sms_pkg::S_LOAD;
            r_job   <= sms_pkg::J_MEAN;
        end else begin
            r_state <= n_state;
            r_job   <= n_job;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_job      = r_job;
        o_in_stall = 1'b1;
        o_cmd      = '0;
        o_cmd.aop  = sms_pkg::A_NONE;
        o_cmd.ma   = sms_pkg::OP_AD;
        o_cmd.mb   = sms_pkg::OP_AD;
        o_cmd.wop  = sms_pkg::W_HOLD;
        o_cmd.job  = r_job;
        unique case (r_state)
            sms_pkg::S_LOAD: begin
                o_in_stall = 1'b0;
                o_cmd.take = i_in_valid;
                if (i_in_valid && i_last) begin
                    n_state = sms_pkg::S_CHK;
                end
            end
            sms_pkg::S_CHK: begin
                o_cmd.aop     = sms_pkg::A_CLR;
                o_cmd.idx_clr = 1'b1;
                if (!i_sts.n_ge2) begin
                    n_state = sms_pkg::S_FIN;
                end else begin
                    n_job   = sms_pkg::J_MEAN;
                    n_state = sms_pkg::S_DIV_GO;
                end
            end
            sms_pkg::S_DIV_GO: begin
                o_cmd.div_start = 1'b1;
                n_state = sms_pkg::S_DIV_WAIT;
            end
            sms_pkg::S_DIV_WAIT: begin
                if (i_sts.div_done) begin
                    o_cmd.div_wr = 1'b1;
                    unique case (r_job)
                        sms_pkg::J_MEAN: n_state = sms_pkg::S_P_RD;
                        sms_pkg::J_M2: begin
                            n_job   = sms_pkg::J_M3;
                            n_state = sms_pkg::S_DIV_GO;
                        end
                        sms_pkg::J_M3: begin
                            n_job   = sms_pkg::J_M4;
                            n_state = sms_pkg::S_DIV_GO;
                        end
                        sms_pkg::J_M4:   n_state = sms_pkg::S_SQ_GO;
                        sms_pkg::J_SKEW: n_state = sms_pkg::S_DK0;
                        sms_pkg::J_KURT: begin
                            n_job   = sms_pkg::J_SHARPE;
                            n_state = sms_pkg::S_DIV_GO;
                        end
                        sms_pkg::J_SHARPE: n_state = sms_pkg::S_FIN;
                        default:           n_state = sms_pkg::S_FIN;
                    endcase
                end
            end
            sms_pkg::S_P_RD: begin
                o_cmd.rd = 1'b1;
                n_state = sms_pkg::S_P_DIFF;
            end
            sms_pkg::S_P_DIFF: begin
                o_cmd.diff = 1'b1;
                n_state = sms_pkg::S_P_SQ;
            end
            sms_pkg::S_P_SQ: begin
                o_cmd.mul_en = 1'b1;
                n_state = sms_pkg::S_P_SQW;
            end
            sms_pkg::S_P_SQW: begin
                o_cmd.p2_wr = 1'b1;
                o_cmd.aop   = sms_pkg::A_T2;
                n_state = sms_pkg::S_K0;
            end
            sms_pkg::S_K0: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.ma     = sms_pkg::OP_P2LO;
                n_state = sms_pkg::S_K1;
            end
            sms_pkg::S_K1: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.ma     = sms_pkg::OP_P2HI;
                o_cmd.wop    = sms_pkg::W_LOAD;
                n_state = sms_pkg::S_K2;
            end
            sms_pkg::S_K2: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.ma     = sms_pkg::OP_P2LO;
                o_cmd.mb     = sms_pkg::OP_P2LO;
                o_cmd.wop    = sms_pkg::W_ADD32;
                n_state = sms_pkg::S_K3;
            end
            sms_pkg::S_K3: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.ma     = sms_pkg::OP_P2LO;
                o_cmd.mb     = sms_pkg::OP_P2HI;
                o_cmd.wop    = sms_pkg::W_LOAD;
                o_cmd.aop    = sms_pkg::A_T3;
                n_state = sms_pkg::S_K4;
            end
            sms_pkg::S_K4: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.ma     = sms_pkg::OP_P2HI;
                o_cmd.mb     = sms_pkg::OP_P2LO;
                o_cmd.wop    = sms_pkg::W_ADD32;
                n_state = sms_pkg::S_K5;
            end
            sms_pkg::S_K5: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.ma     = sms_pkg::OP_P2HI;
                o_cmd.mb     = sms_pkg::OP_P2HI;
                o_cmd.wop    = sms_pkg::W_ADD32;
                n_state = sms_pkg::S_K6;
            end
            sms_pkg::S_K6: begin
                o_cmd.wop = sms_pkg::W_ADD64;
                n_state = sms_pkg::S_K7;
            end
            sms_pkg::S_K7: begin
                o_cmd.aop     = sms_pkg::A_T4;
                o_cmd.idx_inc = 1'b1;
                if (i_sts.idx_last) begin
                    n_job   = sms_pkg::J_M2;
                    n_state = sms_pkg::S_DIV_GO;
                end else begin
                    n_state = sms_pkg::S_P_RD;
                end
            end
            sms_pkg::S_SQ_GO: begin
                o_cmd.sqrt_start = 1'b1;
                n_state = sms_pkg::S_SQ_WAIT;
            end
            sms_pkg::S_SQ_WAIT: begin
                if (i_sts.sqrt_done) begin
                    o_cmd.root_wr = 1'b1;
                    n_state = sms_pkg::S_DS0;
                end
            end
            sms_pkg::S_DS0: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.ma     = sms_pkg::OP_M2LO;
                o_cmd.mb     = sms_pkg::OP_ROOT;
                n_state = sms_pkg::S_DS1;
            end
            sms_pkg::S_DS1: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.ma     = sms_pkg::OP_M2HI;
                o_cmd.mb     = sms_pkg::OP_ROOT;
                o_cmd.wop    = sms_pkg::W_LOAD;
                n_state = sms_pkg::S_DS2;
            end
            sms_pkg::S_DS2: begin
                o_cmd.wop = sms_pkg::W_ADD32;
                n_job   = sms_pkg::J_SKEW;
                n_state = sms_pkg::S_DIV_GO;
            end
            sms_pkg::S_DK0: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.ma     = sms_pkg::OP_M2LO;
                o_cmd.mb     = sms_pkg::OP_M2LO;
                n_state = sms_pkg::S_DK1;
            end
            sms_pkg::S_DK1: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.ma     = sms_pkg::OP_M2LO;
                o_cmd.mb     = sms_pkg::OP_M2HI;
                o_cmd.wop    = sms_pkg::W_LOAD;
                n_state = sms_pkg::S_DK2;
            end
            sms_pkg::S_DK2: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.ma     = sms_pkg::OP_M2HI;
                o_cmd.mb     = sms_pkg::OP_M2LO;
                o_cmd.wop    = sms_pkg::W_ADD32;
                n_state = sms_pkg::S_DK3;
            end
            sms_pkg::S_DK3: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.ma     = sms_pkg::OP_M2HI;
                o_cmd.mb     = sms_pkg::OP_M2HI;
                o_cmd.wop    = sms_pkg::W_ADD32;
                n_state = sms_pkg::S_DK4;
            end
            sms_pkg::S_DK4: begin
                o_cmd.wop = sms_pkg::W_ADD64;
                n_job   = sms_pkg::J_KURT;
                n_state = sms_pkg::S_DIV_GO;
            end
            sms_pkg::S_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load   = 1'b1;
                    o_cmd.clr_series = 1'b1;
                    n_state = sms_pkg::S_LOAD;
                end
            end
            default: n_state = sms_pkg::S_LOAD;
        endcase
    end

endmodule

### rtl/sms_dp.sv
module sms_dp (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  sms_pkg::t_cmd i_cmd,
    input  sms_pkg::t_in  i_in,
    input  logic          i_out_stall,
    output sms_pkg::t_sts o_sts,
    output logic          o_out_valid,
    output sms_pkg::t_out o_out
);

    logic signed [31:0]         mem [sms_pkg::MAX_SAMPLES];
    logic [sms_pkg::SMS_CW-1:0] r_count;
    logic [sms_pkg::SMS_CW-1:0] r_idx;
    logic signed [sms_pkg::SMS_SW-1:0] r_sum;
    logic                       r_flag;
    logic signed [31:0]         r_q;
    logic signed [31:0]         r_mean;
    logic [32:0]                r_ad;
    logic                       r_dneg;
    logic [63:0]                r_p2;
    logic [65:0]                r_prod;
    logic [127:0]               r_wide;
    logic [63:0]                r_acc2;
    logic signed [63:0]         r_acc3;
    logic [63:0]                r_acc4;
    logic [63:0]                r_m2;
    logic [63:0]                r_m3mag;
    logic                       r_m3neg;
    logic [63:0]                r_m4;
    logic [32:0]                r_root;
    logic signed [31:0]         r_skew;
    logic [31:0]                r_kurt;
    logic signed [31:0]         r_sharpe;
    logic                       r_shsat;
    logic                       r_ov;
    sms_pkg::t_out              r_out;

    logic                       room;
    logic [32:0]                mul_a, mul_b;
    logic signed [32:0]         d_w;
    logic [64:0]                t2_sum;
    logic [63:0]                t2;
    logic [127:0]               w3, w4;
    logic [63:0]                t3, t4;
    logic [64:0]                s2, s4;
    logic signed [65:0]         a3, s3;
    logic [sms_pkg::SMS_SW-1:0] sum_mag;
    logic [63:0]                acc3_mag;
    logic [31:0]                am;
    logic [30:0]                sd;
    logic [sms_pkg::SMS_DW-1:0] div_num, div_den, quot;
    logic                       div_busy, div_done;
    logic [63:0]                sq_in;
    logic [32:0]                sq_root;
    logic                       sq_done;
    logic [31:0]                q_lim_skew, q_lim_sh;
    logic                       clip_skew, clip_sh;
    logic [31:0]                mm_skew, mm_sh;
    logic                       guard;
    sms_pkg::t_out              out_n;

    assign room     = (r_count < sms_pkg::SMS_CW'(sms_pkg::MAX_SAMPLES));
    assign sum_mag  = r_sum[sms_pkg::SMS_SW-1] ? sms_pkg::SMS_SW'(-r_sum)
                                               : sms_pkg::SMS_SW'(r_sum);
    assign acc3_mag = r_acc3[63] ? 64'(-r_acc3) : 64'(r_acc3);
    assign am       = r_mean[31] ? 32'(-r_mean) : 32'(r_mean);
    assign sd       = (r_root > 33'h0_7FFF_FFFF) ? 31'h7FFF_FFFF : r_root[30:0];
    assign d_w      = {r_q[31], r_q} - {r_mean[31], r_mean};
    assign t2_sum   = {1'b0, r_prod[63:0]} + 65'(1 << 19);
    assign t2       = 64'(t2_sum[64:20]);
    assign w3       = r_wide + (128'(1) << 47);
    assign t3       = w3[111:48];
    assign w4       = r_wide + (128'(1) << 75);
    assign t4       = 64'(w4[127:76]);
    assign s2       = {1'b0, r_acc2} + {1'b0, t2};
    assign s4       = {1'b0, r_acc4} + {1'b0, t4};
    assign a3       = {{2{r_acc3[63]}}, r_acc3};
    assign s3       = r_dneg ? a3 - $signed({2'b00, t3}) : a3 + $signed({2'b00, t3});
    assign sq_in    = (r_m2 >= (64'(1) << 44)) ? '1 : {r_m2[43:0], 20'b0};

    always_comb begin
        unique case (i_cmd.ma)
            sms_pkg::OP_AD:   mul_a = r_ad;
            sms_pkg::OP_P2LO: mul_a = {1'b0, r_p2[31:0]};
            sms_pkg::OP_P2HI: mul_a = {1'b0, r_p2[63:32]};
            sms_pkg::OP_M2LO: mul_a = {1'b0, r_m2[31:0]};
            sms_pkg::OP_M2HI: mul_a = {1'b0, r_m2[63:32]};
            sms_pkg::OP_ROOT: mul_a = r_root;
            default:          mul_a = '0;
        endcase
        unique case (i_cmd.mb)
            sms_pkg::OP_AD:   mul_b = r_ad;
            sms_pkg::OP_P2LO: mul_b = {1'b0, r_p2[31:0]};
            sms_pkg::OP_P2HI: mul_b = {1'b0, r_p2[63:32]};
            sms_pkg::OP_M2LO: mul_b = {1'b0, r_m2[31:0]};
            sms_pkg::OP_M2HI: mul_b = {1'b0, r_m2[63:32]};
            sms_pkg::OP_ROOT: mul_b = r_root;
            default:          mul_b = '0;
        endcase
    end

    always_comb begin
        unique case (i_cmd.job)
            sms_pkg::J_MEAN: begin
                div_num = sms_pkg::SMS_DW'(sum_mag);
                div_den = sms_pkg::SMS_DW'(r_count);
            end
            sms_pkg::J_M2: begin
                div_num = sms_pkg::SMS_DW'(r_acc2);
                div_den = sms_pkg::SMS_DW'(r_count);
            end
            sms_pkg::J_M3: begin
                div_num = sms_pkg::SMS_DW'(acc3_mag);
                div_den = sms_pkg::SMS_DW'(r_count);
            end
            sms_pkg::J_M4: begin
                div_num = sms_pkg::SMS_DW'(r_acc4);
                div_den = sms_pkg::SMS_DW'(r_count);
            end
            sms_pkg::J_SKEW: begin
                div_num = {12'b0, r_m3mag, 52'b0};
                div_den = r_wide;
            end
            sms_pkg::J_KURT: begin
                div_num = {8'b0, r_m4, 56'b0};
                div_den = r_wide;
            end
            sms_pkg::J_SHARPE: begin
                div_num = sms_pkg::SMS_DW'({am, 16'b0});
                div_den = sms_pkg::SMS_DW'(sd);
            end
            default: begin
                div_num = '0;
                div_den = '0;
            end
        endcase
    end

    sms_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_busy  (div_busy),
        .o_done  (div_done),
        .o_quot  (quot)
    );

    sms_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.sqrt_start),
        .i_val   (sq_in),
        .o_done  (sq_done),
        .o_root  (sq_root)
    );

    assign q_lim_skew = r_m3neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    assign clip_skew  = (quot > sms_pkg::SMS_DW'(q_lim_skew));
    assign mm_skew    = clip_skew ? q_lim_skew : quot[31:0];
    assign q_lim_sh   = r_mean[31] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    assign clip_sh    = (quot > sms_pkg::SMS_DW'(q_lim_sh));
    assign mm_sh      = clip_sh ? q_lim_sh : quot[31:0];
    assign guard      = (sd > 31'd1) && ({sd, 30'b0} > 61'(am));

    always_ff @(posedge i_clk) begin
        if (i_cmd.take && room) begin
            mem[r_count[sms_pkg::SMS_AW-1:0]] <= i_in.sample;
        end
        if (i_cmd.rd) begin
            r_q <= mem[r_idx[sms_pkg::SMS_AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.diff) begin
            r_dneg <= d_w[32];
            r_ad   <= d_w[32] ? 33'(-d_w) : 33'(d_w);
        end
        if (i_cmd.mul_en) begin
            r_prod <= 66'(mul_a) * 66'(mul_b);
        end
        if (i_cmd.p2_wr) begin
            r_p2 <= r_prod[63:0];
        end
        unique case (i_cmd.wop)
            sms_pkg::W_HOLD:  r_wide <= r_wide;
            sms_pkg::W_LOAD:  r_wide <= 128'(r_prod);
            sms_pkg::W_ADD32: r_wide <= r_wide + (128'(r_prod) << 32);
            sms_pkg::W_ADD64: r_wide <= r_wide + (128'(r_prod) << 64);
            default:          r_wide <= r_wide;
        endcase
        if (i_cmd.div_wr) begin
            unique case (i_cmd.job)
                sms_pkg::J_MEAN:
                    r_mean <= r_sum[sms_pkg::SMS_SW-1] ? -$signed(quot[31:0])
                                                       : $signed(quot[31:0]);
                sms_pkg::J_M2: r_m2 <= quot[63:0];
                sms_pkg::J_M3: begin
                    r_m3mag <= quot[63:0];
                    r_m3neg <= r_acc3[63] && (quot[63:0] != 64'd0);
                end
                sms_pkg::J_M4: r_m4 <= quot[63:0];
                sms_pkg::J_SKEW:
                    r_skew <= r_m3neg ? -$signed(mm_skew) : $signed(mm_skew);
                sms_pkg::J_KURT:
                    r_kurt <= (quot[127:32] != '0) ? 32'hFFFF_FFFF : quot[31:0];
                sms_pkg::J_SHARPE: begin
                    r_sharpe <= r_mean[31] ? -$signed(mm_sh) : $signed(mm_sh);
                    r_shsat  <= clip_sh;
                end
                default: r_m4 <= r_m4;
            endcase
        end
        if (i_cmd.root_wr) begin
            r_root <= sq_root;
        end
        if (i_cmd.out_load) begin
            r_out <= out_n;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_sum   <= '0;
            r_flag  <= 1'b0;
            r_idx   <= '0;
            r_acc2  <= '0;
            r_acc3  <= '0;
            r_acc4  <= '0;
            r_ov    <= 1'b0;
        end else begin
            if (i_cmd.clr_series) begin
                r_count <= '0;
                r_sum   <= '0;
                r_flag  <= 1'b0;
            end else if (i_cmd.take) begin
                if (room) begin
                    r_count <= r_count + 1'b1;
                    r_sum   <= r_sum + sms_pkg::SMS_SW'(i_in.sample);
                end else begin
                    r_flag <= 1'b1;
                end
            end
            if (i_cmd.idx_clr) begin
                r_idx <= '0;
            end else if (i_cmd.idx_inc) begin
                r_idx <= r_idx + 1'b1;
            end
            unique case (i_cmd.aop)
                sms_pkg::A_NONE: r_acc2 <= r_acc2;
                sms_pkg::A_CLR: begin
                    r_acc2 <= '0;
                    r_acc3 <= '0;
                    r_acc4 <= '0;
                end
                sms_pkg::A_T2: r_acc2 <= s2[64] ? '1 : s2[63:0];
                sms_pkg::A_T3: begin
                    if (s3[65:63] == 3'b000 || s3[65:63] == 3'b111) begin
                        r_acc3 <= s3[63:0];
                    end else begin
                        r_acc3 <= s3[65] ? 64'sh8000_0000_0000_0000
                                         : 64'sh7FFF_FFFF_FFFF_FFFF;
                    end
                end
                sms_pkg::A_T4: r_acc4 <= s4[64] ? '1 : s4[63:0];
                default: r_acc2 <= r_acc2;
            endcase
            if (i_cmd.out_load) begin
                r_ov <= 1'b1;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_comb begin
        out_n                  = '0;
        out_n.count            = 11'(r_count);
        out_n.dropped          = r_flag;
        if (o_sts.n_ge2) begin
            out_n.mean  = r_mean;
            out_n.stdev = sd;
            if (r_m2 != 64'd0) begin
                out_n.skew     = r_skew;
                out_n.kurtosis = r_kurt;
            end
            if (guard) begin
                out_n.sharpe           = r_sharpe;
                out_n.sharpe_saturated = r_shsat;
            end
        end
    end

    assign o_sts.n_ge2     = (r_count >= sms_pkg::SMS_CW'(2));
    assign o_sts.idx_last  = (r_idx == r_count - 1'b1);
    assign o_sts.div_done  = div_done;
    assign o_sts.sqrt_done = sq_done;
    assign o_sts.out_free  = !r_ov || !i_out_stall;
    assign o_out_valid     = r_ov;
    assign o_out           = r_out;

    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_start |-> !div_busy)
        else $error("divider started while busy");
    a_out_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> !(r_ov && i_out_stall))
        else $error("result overwritten while held");
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= sms_pkg::SMS_CW'(sms_pkg::MAX_SAMPLES))
        else $error("sample count beyond capacity");
    a_rd_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rd |-> r_idx < r_count)
        else $error("read past stored samples");

endmodule

### rtl/sample_moments_sharpe_unit.sv
// Samples are taken one beat per cycle while o_in_stall is low; the store is
// written at the sample count. After the last beat, for two or more samples,
// each stored sample makes a pass through one shared 33x33 multiplier, and the
// result takes seven bit-serial divisions and a bit-serial square root.
// New samples are accepted again as soon as the result sits in the output register.
// Reset is synchronous and active low; it clears control state, not the sample store.
module sample_moments_sharpe_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  sms_pkg::t_in  i_in,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output sms_pkg::t_out o_out
);

    sms_pkg::t_cmd cmd;
    sms_pkg::t_sts sts;

    sms_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_last     (i_in.last),
        .i_sts      (sts),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    sms_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in        (i_in),
        .i_out_stall (i_out_stall),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

endmodule
